FILE: rtl/cld_pkg.sv
// ----------------------------------------------------------------------------
// cld_pkg: shared definitions for the content-length deframer
// Result kinds, header line parser state, character codes and the field
// name table.
// ----------------------------------------------------------------------------
package cld_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 27;
    localparam logic [31:0] MAX_MESSAGE_DEFAULT = 32'd67108864;

    localparam logic [3:0] NAME_LEN = 4'd14;
    localparam logic [3:0] NO_MATCH = 4'd15;

    localparam logic REG_MAX_MESSAGE = 1'b0;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef enum logic [1:0] {
        KIND_HDR_BYTE = 2'd0,
        KIND_HDR_DONE = 2'd1,
        KIND_BODY     = 2'd2,
        KIND_ERROR    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        VP_SKIP   = 2'd0,
        VP_SIGN   = 2'd1,
        VP_DIGITS = 2'd2,
        VP_DONE   = 2'd3
    } value_phase_t;

    typedef struct packed {
        logic [3:0]   name_pos;
        logic         colon_seen;
        value_phase_t vphase;
        logic         negative;
    } line_ctl_t;

    // lower-case header field name, one character per match position
    function automatic logic [7:0] name_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h6C; // l
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/cld_apb_regs.sv
// ----------------------------------------------------------------------------
// cld_apb_regs: configuration register file
// APB-style access to the max_message limit.
// ----------------------------------------------------------------------------
module cld_apb_regs #(
    parameter int COUNT_WIDTH = cld_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output logic [COUNT_WIDTH-1:0] max_message
);

    localparam logic [COUNT_WIDTH-1:0] MAX_RESET =
        COUNT_WIDTH'(cld_pkg::MAX_MESSAGE_DEFAULT);

    logic [COUNT_WIDTH-1:0] max_message_reg;
    logic                   wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & (paddr[2] == cld_pkg::REG_MAX_MESSAGE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_message_reg <= MAX_RESET;
        end
        else if (wr_en)
        begin
            max_message_reg <= pwdata[COUNT_WIDTH-1:0];
        end
    end

    assign prdata      = (paddr[2] == cld_pkg::REG_MAX_MESSAGE) ? 32'(max_message_reg) : 32'd0;
    assign max_message = max_message_reg;

endmodule

FILE: rtl/cld_line_parse.sv
// ----------------------------------------------------------------------------
// cld_line_parse: header line parser
// Matches the field name, then takes the value: blanks, sign, saturating
// decimal digits. Reports the length at the end of a matching line.
// ----------------------------------------------------------------------------
module cld_line_parse #(
    parameter int COUNT_WIDTH = cld_pkg::COUNT_WIDTH_DEFAULT
) (
    input  cld_pkg::line_ctl_t   ctl_in,
    input  logic [COUNT_WIDTH:0] accum_in,
    input  logic [7:0]           byte_in,
    input  logic                 eol,
    output cld_pkg::line_ctl_t   ctl_out,
    output logic [COUNT_WIDTH:0] accum_out,
    output logic                 len_set,
    output logic [COUNT_WIDTH:0] len_value
);

    localparam int PW = COUNT_WIDTH + 5;
    localparam logic [COUNT_WIDTH:0] CAP = {1'b1, {COUNT_WIDTH{1'b0}}};

    logic [7:0]    lower;
    logic          is_digit;
    logic          is_blank;
    logic          run_digit;
    logic [PW-1:0] product;

    assign lower    = (byte_in inside {[8'h41:8'h5A]}) ? byte_in + 8'd32 : byte_in;
    assign is_digit = byte_in inside {[8'h30:8'h39]};
    assign is_blank = byte_in inside {cld_pkg::CH_SPACE, cld_pkg::CH_TAB,
                                      cld_pkg::CH_VT, cld_pkg::CH_FF};
    assign product  = (PW'(accum_in) << 3) + (PW'(accum_in) << 1)
                    + PW'(byte_in - cld_pkg::CH_ZERO);

    always_comb
    begin
        ctl_out   = ctl_in;
        accum_out = accum_in;
        len_set   = 1'b0;
        len_value = accum_in;
        run_digit = 1'b0;
        if (ctl_in.negative && (accum_in != '0))
        begin
            len_value = CAP;
        end
        if (eol)
        begin
            len_set   = ctl_in.colon_seen && (ctl_in.name_pos == cld_pkg::NAME_LEN);
            ctl_out   = '0;
            accum_out = '0;
        end
        else if (!ctl_in.colon_seen)
        begin
            if (byte_in == cld_pkg::CH_COLON)
            begin
                ctl_out.colon_seen = 1'b1;
            end
            else if ((ctl_in.name_pos < cld_pkg::NAME_LEN)
                     && (lower == cld_pkg::name_char(ctl_in.name_pos)))
            begin
                ctl_out.name_pos = ctl_in.name_pos + 4'd1;
            end
            else
            begin
                ctl_out.name_pos = cld_pkg::NO_MATCH;
            end
        end
        else if (ctl_in.name_pos == cld_pkg::NAME_LEN)
        begin
            case (ctl_in.vphase)
                cld_pkg::VP_SKIP:
                begin
                    if (byte_in == cld_pkg::CH_PLUS || byte_in == cld_pkg::CH_MINUS)
                    begin
                        ctl_out.negative = (byte_in == cld_pkg::CH_MINUS);
                        ctl_out.vphase   = cld_pkg::VP_SIGN;
                    end
                    else if (!is_blank)
                    begin
                        run_digit = 1'b1;
                    end
                end
                cld_pkg::VP_SIGN, cld_pkg::VP_DIGITS:
                begin
                    run_digit = 1'b1;
                end
                default:
                begin
                    run_digit = 1'b0;
                end
            endcase
            if (run_digit)
            begin
                if (!is_digit)
                begin
                    ctl_out.vphase = cld_pkg::VP_DONE;
                end
                else
                begin
                    ctl_out.vphase = cld_pkg::VP_DIGITS;
                    accum_out = (product > PW'(CAP)) ? CAP : product[COUNT_WIDTH:0];
                end
            end
        end
    end

endmodule

FILE: rtl/cld_frame_ctrl.sv
// ----------------------------------------------------------------------------
// cld_frame_ctrl: framing state machine and result register
// Tracks the header terminator, collects the length, counts header and
// body bytes and registers one result per byte.
// ----------------------------------------------------------------------------
module cld_frame_ctrl #(
    parameter int COUNT_WIDTH = cld_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [COUNT_WIDTH-1:0] max_message,
    input  logic                   item_valid,
    input  logic [7:0]             item_byte,
    output logic                   item_take,
    input  logic                   out_ready,
    output logic                   out_valid,
    output cld_pkg::kind_t         out_kind,
    output logic [7:0]             out_byte,
    output logic                   out_last,
    output logic [COUNT_WIDTH-1:0] out_length
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_ERROR
    } phase_t;

    typedef enum logic [2:0] {
        TT_NONE,
        TT_CR,
        TT_CRLF,
        TT_CRLFCR,
        TT_LF
    } term_t;

    phase_t                 phase_reg, phase_next;
    term_t                  track_reg, track_next, track_upd;
    cld_pkg::line_ctl_t     ctl_reg, ctl_next, lp_ctl;
    logic [COUNT_WIDTH:0]   accum_reg, accum_next, lp_accum;
    logic                   have_len_reg, have_len_next, have_upd;
    logic [COUNT_WIDTH:0]   declared_reg, declared_next, decl_upd, lp_len_value;
    logic [COUNT_WIDTH-1:0] hdr_count_reg, hdr_count_next;
    logic [COUNT_WIDTH-1:0] body_rem_reg, body_rem_next, rem_dec;
    logic                   nul_reg, nul_next;
    logic                   out_valid_reg, out_valid_next;
    cld_pkg::kind_t         kind_reg, kind_next;
    logic [7:0]             byte_reg, byte_next;
    logic                   last_reg, last_next;
    logic [COUNT_WIDTH-1:0] length_reg, length_next;

    logic lp_len_set;
    logic is_cr;
    logic is_lf;
    logic nul_now;
    logic done;
    logic too_long;

    cld_line_parse #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_line_parse (
        .ctl_in    (ctl_reg),
        .accum_in  (accum_reg),
        .byte_in   (item_byte),
        .eol       (is_cr | is_lf),
        .ctl_out   (lp_ctl),
        .accum_out (lp_accum),
        .len_set   (lp_len_set),
        .len_value (lp_len_value)
    );

    assign item_take = item_valid & (~out_valid_reg | out_ready);
    assign is_cr     = (item_byte == cld_pkg::CH_CR);
    assign is_lf     = (item_byte == cld_pkg::CH_LF);
    assign nul_now   = nul_reg | (item_byte == cld_pkg::CH_NUL);
    assign done      = ~nul_now & is_lf
                     & (track_reg == TT_CRLF || track_reg == TT_CRLFCR || track_reg == TT_LF);
    assign have_upd  = have_len_reg | (~nul_now & lp_len_set);
    assign decl_upd  = (~nul_now & lp_len_set) ? lp_len_value : declared_reg;
    assign too_long  = decl_upd > {1'b0, max_message};
    assign rem_dec   = (body_rem_reg != '0) ? body_rem_reg - COUNT_WIDTH'(1) : body_rem_reg;

    always_comb
    begin
        if (done)
        begin
            track_upd = track_reg;
        end
        else if (is_lf)
        begin
            track_upd = (track_reg == TT_CR) ? TT_CRLF : TT_LF;
        end
        else if (is_cr)
        begin
            track_upd = (track_reg == TT_CRLF) ? TT_CRLFCR : TT_CR;
        end
        else
        begin
            track_upd = TT_NONE;
        end
    end

    always_comb
    begin
        logic header_clear;
        header_clear   = 1'b0;
        phase_next     = phase_reg;
        track_next     = track_reg;
        ctl_next       = ctl_reg;
        accum_next     = accum_reg;
        have_len_next  = have_len_reg;
        declared_next  = declared_reg;
        hdr_count_next = hdr_count_reg;
        body_rem_next  = body_rem_reg;
        nul_next       = nul_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        length_next    = length_reg;
        if (item_take)
        begin
            out_valid_next = 1'b1;
            kind_next      = cld_pkg::KIND_ERROR;
            byte_next      = 8'd0;
            last_next      = 1'b0;
            length_next    = '0;
            case (phase_reg)
                PH_BODY:
                begin
                    kind_next     = cld_pkg::KIND_BODY;
                    byte_next     = item_byte;
                    body_rem_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        last_next    = 1'b1;
                        phase_next   = PH_HEADER;
                        header_clear = 1'b1;
                    end
                end
                PH_HEADER:
                begin
                    nul_next = nul_now;
                    if (!nul_now)
                    begin
                        track_next    = track_upd;
                        ctl_next      = lp_ctl;
                        accum_next    = lp_accum;
                        have_len_next = have_upd;
                        declared_next = decl_upd;
                    end
                    if (done)
                    begin
                        if (!have_upd || too_long)
                        begin
                            phase_next = PH_ERROR;
                        end
                        else
                        begin
                            kind_next     = cld_pkg::KIND_HDR_DONE;
                            length_next   = decl_upd[COUNT_WIDTH-1:0];
                            body_rem_next = decl_upd[COUNT_WIDTH-1:0];
                            if (decl_upd == '0)
                            begin
                                last_next    = 1'b1;
                                header_clear = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_BODY;
                            end
                        end
                    end
                    else if (hdr_count_reg >= max_message)
                    begin
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        hdr_count_next = hdr_count_reg + COUNT_WIDTH'(1);
                        kind_next      = cld_pkg::KIND_HDR_BYTE;
                    end
                end
                default:
                begin
                    phase_next = PH_ERROR;
                end
            endcase
            if (header_clear)
            begin
                track_next     = TT_NONE;
                ctl_next       = '0;
                accum_next     = '0;
                have_len_next  = 1'b0;
                declared_next  = '0;
                hdr_count_next = '0;
                nul_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            track_reg     <= TT_NONE;
            ctl_reg       <= '0;
            accum_reg     <= '0;
            have_len_reg  <= 1'b0;
            declared_reg  <= '0;
            hdr_count_reg <= '0;
            body_rem_reg  <= '0;
            nul_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg      <= cld_pkg::KIND_HDR_BYTE;
            byte_reg      <= 8'd0;
            last_reg      <= 1'b0;
            length_reg    <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            track_reg     <= track_next;
            ctl_reg       <= ctl_next;
            accum_reg     <= accum_next;
            have_len_reg  <= have_len_next;
            declared_reg  <= declared_next;
            hdr_count_reg <= hdr_count_next;
            body_rem_reg  <= body_rem_next;
            nul_reg       <= nul_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            byte_reg      <= byte_next;
            last_reg      <= last_next;
            length_reg    <= length_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = kind_reg;
    assign out_byte   = byte_reg;
    assign out_last   = last_reg;
    assign out_length = length_reg;

endmodule

FILE: rtl/content_length_deframer.sv
// ----------------------------------------------------------------------------
// content_length_deframer: header-plus-body stream deframer
// Datapath: an accepted byte is loaded into the input register, and its result
//   into the result register once the framing logic takes the byte.
// Throughput: one byte per cycle unless stalled; one framing pass per byte.
// Reset: asynchronous, active low; returns to header parsing, max_message
//   back to its default, errors cleared.
// ----------------------------------------------------------------------------
module content_length_deframer #(
    parameter int COUNT_WIDTH = cld_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [((COUNT_WIDTH + 15) / 8) * 8 - 1:0] m_axis_tdata,
                                        // body_byte, body_length, zero pad
    output logic        m_axis_tlast,   // body_last
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DATA_W = ((COUNT_WIDTH + 15) / 8) * 8;

    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_byte_reg, in_byte_next;
    logic                   item_take;
    logic [COUNT_WIDTH-1:0] max_message;
    cld_pkg::kind_t         out_kind;
    logic [7:0]             out_byte;
    logic [COUNT_WIDTH-1:0] out_length;

    cld_apb_regs #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .max_message (max_message)
    );

    cld_frame_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_message (max_message),
        .item_valid  (in_valid_reg),
        .item_byte   (in_byte_reg),
        .item_take   (item_take),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_kind    (out_kind),
        .out_byte    (out_byte),
        .out_last    (m_axis_tlast),
        .out_length  (out_length)
    );

    assign s_axis_tready = ~in_valid_reg | item_take;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
            if (s_axis_tvalid)
            begin
                in_byte_next = s_axis_tdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_byte_reg  <= 8'd0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            in_byte_reg  <= in_byte_next;
        end
    end

    assign m_axis_tdata = DATA_W'({out_length, out_byte});
    assign m_axis_tuser = out_kind;

`ifndef ASSERT_OFF
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tuser == cld_pkg::KIND_BODY || m_axis_tuser == cld_pkg::KIND_HDR_DONE)
        else $error("last flag on a result that is neither body nor header end");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser == cld_pkg::KIND_ERROR |=>
            !m_axis_tvalid || m_axis_tuser == cld_pkg::KIND_ERROR)
        else $error("result after an error is not an error");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != cld_pkg::KIND_BODY |-> out_byte == 8'd0)
        else $error("body byte set on a non-body result");

    a_length_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != cld_pkg::KIND_HDR_DONE |-> out_length == '0)
        else $error("length set on a result that is not header end");
`endif

endmodule

FILE: tb/content_length_deframer_test.sv
// ----------------------------------------------------------------------------
// content_length_deframer_test: self-checking bench for the deframer
// Streams framed messages (header lines with a Content-Length field, then a
// body) into the block with random idle cycles on both stream sides. Every
// output transaction is checked field by field against a local model of the
// framing rules. The size limit is rewritten between phases. The run closes
// with one sticky framing error.
// ----------------------------------------------------------------------------
module content_length_deframer_test;

    import cld_pkg::*;

    localparam int COUNT_WIDTH = COUNT_WIDTH_DEFAULT;
    localparam int TDATA_W = ((COUNT_WIDTH + 15) / 8) * 8;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_BYTES = 200;
    localparam logic [COUNT_WIDTH:0] ACC_CAP = {1'b1, {COUNT_WIDTH{1'b0}}};
    localparam logic [8*14-1:0] FIELD_NAME = "content-length";

    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    localparam logic [2:0] TRK_NONE   = 3'd0;
    localparam logic [2:0] TRK_CR     = 3'd1;
    localparam logic [2:0] TRK_CRLF   = 3'd2;
    localparam logic [2:0] TRK_CRLFCR = 3'd3;
    localparam logic [2:0] TRK_LF     = 3'd4;

    typedef enum logic [1:0] {ST_HEADER, ST_BODY, ST_FAILED} frame_phase_t;
    typedef enum int {BRK_CRLF, BRK_LF, BRK_CR} line_break_t;
    typedef enum int {END_CRLFCRLF, END_LFLF, END_CRLFLF} header_end_t;
    typedef enum int {
        ERR_MISSING, ERR_TOO_LONG, ERR_NEGATIVE, ERR_SATURATED, ERR_OVERLONG, ERR_NUL
    } final_error_t;

    typedef struct packed {
        kind_t                  kind;
        logic [7:0]             body_byte;
        logic                   body_last;
        logic [COUNT_WIDTH-1:0] body_length;
    } frame_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;   // [7:0] in_byte
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata; // [7:0] body_byte, [34:8] body_length, zero pad
    logic m_axis_tlast;                // body_last
    logic [1:0] m_axis_tuser;          // [1:0] kind
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic pready;

    logic [7:0] stream_bytes[$];
    logic [7:0] header_bytes[$];
    frame_result_t frame_results_due[$];
    int unsigned mismatch_count = 0;
    int unsigned bytes_planned = 0;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;
    bit in_taken = 1'b0;

    // deframer model state
    logic [COUNT_WIDTH-1:0] limit_cfg = MAX_MESSAGE_DEFAULT[COUNT_WIDTH-1:0];
    frame_phase_t fr_phase = ST_HEADER;
    logic [2:0] term_seen = TRK_NONE;
    logic [3:0] name_pos = 4'd0;
    logic colon_hit = 1'b0;
    value_phase_t num_phase = VP_SKIP;
    logic num_neg = 1'b0;
    logic [COUNT_WIDTH:0] num_acc = '0;
    logic len_known = 1'b0;
    logic [COUNT_WIDTH:0] len_declared = '0;
    logic [COUNT_WIDTH-1:0] hdr_count = '0;
    logic [COUNT_WIDTH-1:0] body_left = '0;
    logic nul_hit = 1'b0;

    content_length_deframer DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #2 clk = ~clk;

    function automatic logic [7:0] field_char(input logic [3:0] pos);
        return FIELD_NAME[8*(13 - pos) +: 8];
    endfunction

    function automatic void clear_line();
        name_pos = 4'd0;
        colon_hit = 1'b0;
        num_phase = VP_SKIP;
        num_neg = 1'b0;
        num_acc = '0;
    endfunction

    function automatic void clear_header();
        term_seen = TRK_NONE;
        clear_line();
        len_known = 1'b0;
        len_declared = '0;
        hdr_count = '0;
        nul_hit = 1'b0;
    endfunction

    function automatic void close_line();
        if (colon_hit && name_pos == NAME_LEN) begin
            len_known = 1'b1;
            len_declared = (num_neg && num_acc != 0) ? ACC_CAP : num_acc;
        end
        clear_line();
    endfunction

    function automatic void scan_line_char(input logic [7:0] b);
        logic [7:0] lc;
        logic [COUNT_WIDTH+8:0] wide;
        bit is_digit;
        bit is_blank;
        lc = (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? (b | CASE_BIT) : b;
        is_digit = (b >= CH_ZERO && b <= CH_NINE);
        is_blank = (b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF);
        if (!colon_hit) begin
            if (b == CH_COLON)
                colon_hit = 1'b1;
            else if (name_pos < NAME_LEN && lc == field_char(name_pos))
                name_pos = name_pos + 4'd1;
            else
                name_pos = NO_MATCH;
        end else if (name_pos == NAME_LEN && num_phase != VP_DONE) begin
            if (num_phase == VP_SKIP && is_blank) begin
                // skip leading blank
            end else if (num_phase == VP_SKIP && (b == CH_PLUS || b == CH_MINUS)) begin
                num_neg = (b == CH_MINUS);
                num_phase = VP_SIGN;
            end else if (!is_digit) begin
                num_phase = VP_DONE;
            end else begin
                num_phase = VP_DIGITS;
                wide = (COUNT_WIDTH+9)'(num_acc) * 10 + (COUNT_WIDTH+9)'(b - CH_ZERO);
                num_acc = (wide > ACC_CAP) ? ACC_CAP : wide[COUNT_WIDTH:0];
            end
        end
    endfunction

    function automatic frame_result_t deframe_byte(input logic [7:0] b);
        frame_result_t res;
        bit done;
        res = '{KIND_ERROR, 8'd0, 1'b0, '0};
        done = 1'b0;
        if (fr_phase == ST_BODY) begin
            res.kind = KIND_BODY;
            res.body_byte = b;
            if (body_left != 0)
                body_left = body_left - 1'b1;
            if (body_left == 0) begin
                res.body_last = 1'b1;
                fr_phase = ST_HEADER;
                clear_header();
            end
        end else if (fr_phase == ST_HEADER) begin
            if (b == CH_NUL)
                nul_hit = 1'b1;
            if (!nul_hit) begin
                if (b == CH_LF) begin
                    if (term_seen == TRK_CRLF || term_seen == TRK_CRLFCR || term_seen == TRK_LF)
                        done = 1'b1;
                    else
                        term_seen = (term_seen == TRK_CR) ? TRK_CRLF : TRK_LF;
                end else if (b == CH_CR) begin
                    term_seen = (term_seen == TRK_CRLF) ? TRK_CRLFCR : TRK_CR;
                end else begin
                    term_seen = TRK_NONE;
                end
                if (b == CH_CR || b == CH_LF)
                    close_line();
                else
                    scan_line_char(b);
            end
            if (done) begin
                if (!len_known || len_declared > {1'b0, limit_cfg}) begin
                    fr_phase = ST_FAILED;
                end else begin
                    res.kind = KIND_HDR_DONE;
                    res.body_length = len_declared[COUNT_WIDTH-1:0];
                    body_left = len_declared[COUNT_WIDTH-1:0];
                    if (len_declared == 0) begin
                        res.body_last = 1'b1;
                        clear_header();
                    end else begin
                        fr_phase = ST_BODY;
                    end
                end
            end else if (hdr_count >= limit_cfg) begin
                fr_phase = ST_FAILED;
            end else begin
                hdr_count = hdr_count + 1'b1;
                res.kind = KIND_HDR_BYTE;
            end
        end
        return res;
    endfunction

    function automatic int unsigned draw_pause(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = ~calm;
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
        $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, want, got);
        mismatch_count++;
    endtask

    // check results, then predict for the input transaction taken at this edge
    always @(posedge clk) begin
        frame_result_t want;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                recv_wait = draw_pause(recv_calm);
                if (frame_results_due.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none actual kind %0d",
                             $time, m_axis_tuser);
                    mismatch_count++;
                end else begin
                    want = frame_results_due.pop_front();
                    if (m_axis_tuser != want.kind)
                        report("kind", want.kind, m_axis_tuser);
                    if (m_axis_tdata[7:0] != want.body_byte)
                        report("body_byte", want.body_byte, m_axis_tdata[7:0]);
                    if (m_axis_tdata[COUNT_WIDTH+7:8] != want.body_length)
                        report("body_length", want.body_length, m_axis_tdata[COUNT_WIDTH+7:8]);
                    if (m_axis_tdata[TDATA_W-1:COUNT_WIDTH+8] != 0)
                        report("tdata pad", 0, m_axis_tdata[TDATA_W-1:COUNT_WIDTH+8]);
                    if (m_axis_tlast != want.body_last)
                        report("body_last", want.body_last, m_axis_tlast);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                frame_results_due.push_back(deframe_byte(s_axis_tdata));
                in_taken = 1'b1;
            end
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            in_taken = 1'b0;
            if (send_wait > 0) begin
                s_axis_tvalid <= 1'b0;
                send_wait = send_wait - 1;
            end else if (stream_bytes.size() > 0) begin
                s_axis_tdata <= stream_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
                send_wait = draw_pause(send_calm);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (recv_wait > 0) begin
            m_axis_tready <= 1'b0;
            recv_wait = recv_wait - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic wait_idle();
        while (stream_bytes.size() != 0 || s_axis_tvalid || frame_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_limit(input logic [COUNT_WIDTH-1:0] value);
        wait_idle();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_MAX_MESSAGE, 2'b00};
        pwdata <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        limit_cfg = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata != 32'(value))
            report("max_message readback", 32'(value), prdata);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        while (b == CH_LF || b == CH_CR)
            b = 8'($urandom_range(1, 255));
        return b;
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            header_bytes.push_back(s[i]);
    endfunction

    function automatic void push_break();
        case (line_break_t'($urandom_range(0, 2)))
            BRK_CRLF: begin header_bytes.push_back(CH_CR); header_bytes.push_back(CH_LF); end
            BRK_LF:   header_bytes.push_back(CH_LF);
            default:  header_bytes.push_back(CH_CR);
        endcase
    endfunction

    function automatic void push_header_end();
        case (header_end_t'($urandom_range(0, 2)))
            END_CRLFCRLF: begin
                header_bytes.push_back(CH_CR);
                header_bytes.push_back(CH_LF);
                header_bytes.push_back(CH_CR);
                header_bytes.push_back(CH_LF);
            end
            END_LFLF: begin
                header_bytes.push_back(CH_LF);
                header_bytes.push_back(CH_LF);
            end
            default: begin
                header_bytes.push_back(CH_CR);
                header_bytes.push_back(CH_LF);
                header_bytes.push_back(CH_LF);
            end
        endcase
    endfunction

    function automatic void push_field_name();
        logic [7:0] c;
        for (int i = 0; i < 14; i++) begin
            c = field_char(4'(i));
            if (c >= CH_LOWER_A && c <= CH_LOWER_Z && $urandom_range(0, 1))
                c = c & ~CASE_BIT;
            header_bytes.push_back(c);
        end
        header_bytes.push_back(CH_COLON);
    endfunction

    function automatic void push_blanks();
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 3))
                0:       header_bytes.push_back(CH_SPACE);
                1:       header_bytes.push_back(CH_TAB);
                2:       header_bytes.push_back(CH_VT);
                default: header_bytes.push_back(CH_FF);
            endcase
        end
    endfunction

    function automatic void push_other_line();
        case ($urandom_range(0, 3))
            0: repeat ($urandom_range(1, 10)) header_bytes.push_back(text_byte());
            1: begin
                push_text("X-Tag:");
                repeat ($urandom_range(1, 6)) header_bytes.push_back(text_byte());
            end
            2: begin
                case ($urandom_range(0, 4))
                    0:       push_text("Content-Lengt: 9");
                    1:       push_text("Content-Length : 9");
                    2:       push_text("XContent-Length: 9");
                    3:       push_text("Content-Lengthh: 9");
                    default: push_text("Content_Length: 9");
                endcase
            end
            default: begin
                push_field_name();
                push_blanks();
                if ($urandom_range(0, 2) == 0)
                    header_bytes.push_back(CH_MINUS);
                push_text($sformatf("%0d", $urandom()));
            end
        endcase
    endfunction

    function automatic void push_length_line(input int unsigned len);
        push_field_name();
        push_blanks();
        if (len == 0) begin
            case ($urandom_range(0, 5))
                0:       ;
                1:       push_text("0");
                2:       push_text("-0");
                3:       push_text("+");
                4:       push_text("-");
                default: push_text("+000");
            endcase
        end else begin
            if ($urandom_range(0, 3) == 0)
                header_bytes.push_back(CH_PLUS);
            repeat ($urandom_range(0, 2)) header_bytes.push_back(CH_ZERO);
            push_text($sformatf("%0d", len));
        end
        if ($urandom_range(0, 3) == 0) begin
            header_bytes.push_back($urandom_range(0, 1) ? CH_COLON
                                   : 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z)));
            repeat ($urandom_range(0, 3)) header_bytes.push_back(text_byte());
        end
    endfunction

    function automatic void commit_header();
        while (header_bytes.size() > 0)
            stream_bytes.push_back(header_bytes.pop_front());
    endfunction

    function automatic void push_body(input int unsigned len);
        repeat (len) stream_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void queue_message(input int unsigned len);
        int room;
        header_bytes.delete();
        repeat ($urandom_range(0, 3)) begin
            push_other_line();
            push_break();
        end
        push_length_line(len);
        push_header_end();
        if (header_bytes.size() > int'(limit_cfg) + 1) begin
            header_bytes.delete();
            push_text($sformatf("Content-Length:%0d", len));
            header_bytes.push_back(CH_LF);
            header_bytes.push_back(CH_LF);
        end
        // fill the header up to exactly the byte limit now and then
        room = int'(limit_cfg) + 1 - header_bytes.size();
        if (room >= 2 && room <= 200 && $urandom_range(0, 1)) begin
            header_bytes.push_front(CH_LF);
            repeat (room - 1) header_bytes.push_front(text_byte());
        end
        bytes_planned += header_bytes.size() + len;
        commit_header();
        push_body(len);
    endfunction

    function automatic int unsigned pick_length();
        int unsigned r;
        int unsigned len;
        r = $urandom_range(0, 15);
        if (r < 3)
            len = 0;
        else if (r == 15)
            len = (limit_cfg <= 64) ? int'(limit_cfg) : $urandom_range(13, 48);
        else
            len = $urandom_range(1, 12);
        return (len > int'(limit_cfg)) ? int'(limit_cfg) : len;
    endfunction

    initial begin
        logic [COUNT_WIDTH-1:0] phase_limits[5];
        phase_limits = '{MAX_MESSAGE_DEFAULT[COUNT_WIDTH-1:0], 20, 4096, 37,
                         MAX_MESSAGE_DEFAULT[COUNT_WIDTH-1:0]};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero length, no blanks, lower case
        push_text("content-length:0");
        header_bytes.push_back(CH_LF);
        header_bytes.push_back(CH_LF);
        commit_header();
        // upper case, tab and plus sign, extreme body bytes
        push_text("CONTENT-LENGTH:\t+2");
        header_bytes.push_back(CH_CR);
        header_bytes.push_back(CH_LF);
        header_bytes.push_back(CH_CR);
        header_bytes.push_back(CH_LF);
        commit_header();
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'hFF);
        // later line wins, minus zero is zero
        push_text("Content-Length: 1");
        header_bytes.push_back(CH_LF);
        push_text("Content-Length: -0");
        header_bytes.push_back(CH_CR);
        header_bytes.push_back(CH_LF);
        header_bytes.push_back(CH_LF);
        commit_header();

        foreach (phase_limits[p]) begin
            set_limit(phase_limits[p]);
            bytes_planned = 0;
            while (bytes_planned < PHASE_BYTES)
                queue_message(pick_length());
        end

        wait_idle();
        case (final_error_t'($urandom_range(0, 5)))
            ERR_MISSING:   push_text("Host: a");
            ERR_TOO_LONG:  push_text($sformatf("Content-Length: %0d", limit_cfg + 1));
            ERR_NEGATIVE:  push_text("Content-Length: -7");
            ERR_SATURATED: push_text("Content-Length: 123456789012");
            ERR_OVERLONG: begin
                set_limit('0);
                push_text("Content-Length: 0");
            end
            default: begin
                set_limit(16);
                push_text("Content-Length: 3");
                header_bytes.push_back(CH_NUL);
            end
        endcase
        push_header_end();
        push_text("abcdefghij");
        commit_header();
        push_body(24);

        wait_idle();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
